/* rtl/tclf_pkg.sv */
// Shared types and codes for the text cell layout engine.
// Used by the front end, the command queue and the back end. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tclf_pkg;

    localparam int KIND_W = 2;
    localparam int CHAR_W = 8;

    // Item kinds carried on s_tuser
    localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Control characters
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    // Commands handed from the front end to the back end
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
    localparam logic [OP_W-1:0] OP_PRINT = 3'd1;
    localparam logic [OP_W-1:0] OP_LF    = 3'd2;
    localparam logic [OP_W-1:0] OP_BS    = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/tclf_front.sv */
// Front end: takes input transactions and decodes them into queue commands.
// Depends on tclf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tclf_front (
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,   // [7:0] char_code
    input  wire logic [1:0]                 s_tuser,   // [1:0] kind
    input  wire logic                       q_full,
    input  wire logic                       init_busy,
    output logic                            q_push,
    output tclf_pkg::cmd_t                  q_cmd
);
    import tclf_pkg::*;

    // Accept while the queue has room and the power-up fill is done
    assign s_tready = !q_full && !init_busy;
    assign q_push   = s_tvalid && s_tready;

    // Decode kind and character into a command
    always_comb begin
        q_cmd.ch = s_tdata;
        case (s_tuser)
            KIND_CHAR: begin
                case (s_tdata)
                    CHAR_CR: q_cmd.op = OP_NONE;
                    CHAR_LF: q_cmd.op = OP_LF;
                    CHAR_BS: q_cmd.op = OP_BS;
                    default: q_cmd.op = OP_PRINT;
                endcase
            end
            KIND_FLUSH: q_cmd.op = OP_FLUSH;
            KIND_CLEAR: q_cmd.op = OP_CLEAR;
            default:    q_cmd.op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/tclf_queue.sv */
// Short command queue between the front end and the back end.
// Depends on tclf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tclf_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire tclf_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output tclf_pkg::cmd_t      head_cmd
);
    import tclf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/tclf_back.sv */
// Back end: cursor, text and painted row memories, scroll and flush sequencer,
// and the result register. Depends on tclf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tclf_back #(
    parameter int TEXT_ROWS = 12,
    parameter int TEXT_COLS = 16,
    localparam int COL_W   = $clog2(TEXT_COLS + 1),
    localparam int ROW_W   = $clog2(TEXT_ROWS),
    localparam int CIDX_W  = $clog2(TEXT_COLS),
    localparam int OUT_BITS = 2 * COL_W - COL_W + 2 * ROW_W + CIDX_W + 12,
    localparam int OUT_W   = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    input  wire tclf_pkg::cmd_t     q_cmd,
    output logic                    q_pop,
    output logic                    init_busy,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [OUT_W-1:0]        m_tdata
);
    import tclf_pkg::*;

    localparam int LINE_W = TEXT_COLS * CHAR_W;

    localparam logic [2:0] ST_FILL   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SC_MV  = 3'd2;
    localparam logic [2:0] ST_SC_END = 3'd3;
    localparam logic [2:0] ST_FL_CMP = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(TEXT_ROWS - 1);
    localparam logic [LINE_W-1:0] SPACE_LINE = {TEXT_COLS{CHAR_SPACE}};

    // Row-wide memories with byte enables
    logic [LINE_W-1:0] text_mem  [TEXT_ROWS];
    logic [LINE_W-1:0] paint_mem [TEXT_ROWS];
    logic [LINE_W-1:0] text_rd_reg, paint_rd_reg;
    logic [ROW_W-1:0]  rd_addr;

    logic                 text_we, paint_we;
    logic [ROW_W-1:0]     text_waddr, paint_waddr;
    logic [LINE_W-1:0]    text_wdata, paint_wdata;
    logic [TEXT_COLS-1:0] text_be, paint_be;

    logic [2:0]        state_reg, state_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic              pending_reg, pending_next;
    cmd_t              cmd_reg, cmd_next;
    logic [ROW_W-1:0]  step_row_reg, step_row_next;
    logic              fill_clear_reg, fill_clear_next;

    logic              res_scrolled_reg, res_scrolled_next;
    logic              res_valid_reg, res_valid_next;
    logic [ROW_W-1:0]  res_crow_reg, res_crow_next;
    logic [CIDX_W-1:0] res_ccol_reg, res_ccol_next;
    logic [CHAR_W-1:0] res_cchar_reg, res_cchar_next;
    logic              res_done_reg, res_done_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  m_tdata_reg;
    logic              out_load;
    logic [OUT_BITS-1:0] out_bits;

    logic [TEXT_COLS-1:0] diff;
    logic [CIDX_W-1:0]    first_col;
    logic                 any_diff;
    logic [CIDX_W-1:0]    col_idx;
    logic [ROW_W-1:0]     row_inc;

    assign init_busy = (state_reg == ST_FILL) && !fill_clear_reg;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign col_idx   = cur_col_reg[CIDX_W-1:0];
    assign row_inc   = step_row_reg + ROW_W'(1);

    // Compare one text row against its painted copy, find first differing column
    always_comb begin
        first_col = '0;
        for (int c = 0; c < TEXT_COLS; c++) begin
            diff[c] = (text_rd_reg[c*CHAR_W +: CHAR_W] != paint_rd_reg[c*CHAR_W +: CHAR_W]);
        end
        for (int c = TEXT_COLS - 1; c >= 0; c--) begin
            if (diff[c]) begin
                first_col = CIDX_W'(c);
            end
        end
        any_diff = |diff;
    end

    // Sequencer
    always_comb begin
        state_next        = state_reg;
        cur_col_next      = cur_col_reg;
        cur_row_next      = cur_row_reg;
        pending_next      = pending_reg;
        cmd_next          = cmd_reg;
        step_row_next     = step_row_reg;
        fill_clear_next   = fill_clear_reg;
        res_scrolled_next = res_scrolled_reg;
        res_valid_next    = res_valid_reg;
        res_crow_next     = res_crow_reg;
        res_ccol_next     = res_ccol_reg;
        res_cchar_next    = res_cchar_reg;
        res_done_next     = res_done_reg;
        rd_addr           = step_row_reg;
        text_we           = 1'b0;
        text_waddr        = '0;
        text_wdata        = '0;
        text_be           = '0;
        paint_we          = 1'b0;
        paint_waddr       = '0;
        paint_wdata       = '0;
        paint_be          = '0;
        q_pop             = 1'b0;
        out_load          = 1'b0;

        case (state_reg)
            // Sweep rows: power-up fill, or clear screen
            ST_FILL: begin
                text_we     = 1'b1;
                text_waddr  = step_row_reg;
                text_wdata  = SPACE_LINE;
                text_be     = '1;
                paint_we    = 1'b1;
                paint_waddr = step_row_reg;
                paint_wdata = fill_clear_reg ? SPACE_LINE : '0;
                paint_be    = '1;
                if (step_row_reg == LAST_ROW) begin
                    cur_col_next = '0;
                    cur_row_next = '0;
                    pending_next = 1'b0;
                    state_next   = fill_clear_reg ? ST_RESULT : ST_IDLE;
                end else begin
                    step_row_next = row_inc;
                end
            end

            // Take a command and do the cases that need no row sweep right away
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop             = 1'b1;
                    cmd_next          = q_cmd;
                    res_scrolled_next = 1'b0;
                    res_valid_next    = 1'b0;
                    res_crow_next     = '0;
                    res_ccol_next     = '0;
                    res_cchar_next    = '0;
                    res_done_next     = 1'b0;
                    state_next        = ST_RESULT;
                    case (q_cmd.op)
                        OP_LF: begin
                            cur_col_next = '0;
                            if (cur_row_reg == LAST_ROW) begin
                                res_scrolled_next = 1'b1;
                                pending_next      = 1'b1;
                                step_row_next     = '0;
                                rd_addr           = ROW_W'(1);
                                state_next        = ST_SC_MV;
                            end else begin
                                cur_row_next = cur_row_reg + ROW_W'(1);
                            end
                        end
                        OP_BS: begin
                            if (cur_col_reg != '0) begin
                                cur_col_next = cur_col_reg - COL_W'(1);
                            end else if (cur_row_reg != '0) begin
                                cur_row_next = cur_row_reg - ROW_W'(1);
                                cur_col_next = COL_W'(TEXT_COLS - 1);
                            end
                        end
                        OP_PRINT: begin
                            pending_next = 1'b1;
                            text_wdata   = {TEXT_COLS{q_cmd.ch}};
                            if (cur_col_reg == COL_W'(TEXT_COLS)) begin
                                if (cur_row_reg == LAST_ROW) begin
                                    res_scrolled_next = 1'b1;
                                    step_row_next     = '0;
                                    rd_addr           = ROW_W'(1);
                                    state_next        = ST_SC_MV;
                                end else begin
                                    text_we      = 1'b1;
                                    text_waddr   = cur_row_reg + ROW_W'(1);
                                    text_be      = TEXT_COLS'(1);
                                    cur_row_next = cur_row_reg + ROW_W'(1);
                                    cur_col_next = COL_W'(1);
                                end
                            end else begin
                                text_we      = 1'b1;
                                text_waddr   = cur_row_reg;
                                text_be      = TEXT_COLS'(1) << col_idx;
                                cur_col_next = cur_col_reg + COL_W'(1);
                            end
                        end
                        OP_FLUSH: begin
                            step_row_next = '0;
                            rd_addr       = '0;
                            state_next    = ST_FL_CMP;
                        end
                        OP_CLEAR: begin
                            step_row_next   = '0;
                            fill_clear_next = 1'b1;
                            state_next      = ST_FILL;
                        end
                        default: begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end

            // Move each row up by one; read two rows ahead of the write
            ST_SC_MV: begin
                text_we    = 1'b1;
                text_waddr = step_row_reg;
                text_wdata = text_rd_reg;
                text_be    = '1;
                if (step_row_reg == ROW_W'(TEXT_ROWS - 2)) begin
                    state_next = ST_SC_END;
                end else begin
                    step_row_next = row_inc;
                    rd_addr       = row_inc + ROW_W'(1);
                end
            end

            // Blank the bottom row, placing a wrapped character in column 0
            ST_SC_END: begin
                text_we    = 1'b1;
                text_waddr = LAST_ROW;
                text_be    = '1;
                if (cmd_reg.op == OP_PRINT) begin
                    text_wdata   = {SPACE_LINE[LINE_W-1:CHAR_W], cmd_reg.ch};
                    cur_col_next = COL_W'(1);
                end else begin
                    text_wdata   = SPACE_LINE;
                    cur_col_next = '0;
                end
                cur_row_next = LAST_ROW;
                state_next   = ST_RESULT;
            end

            // Scan rows one per cycle for the first changed cell
            ST_FL_CMP: begin
                if (any_diff) begin
                    paint_we       = 1'b1;
                    paint_waddr    = step_row_reg;
                    paint_wdata    = text_rd_reg;
                    paint_be       = TEXT_COLS'(1) << first_col;
                    res_valid_next = 1'b1;
                    res_crow_next  = step_row_reg;
                    res_ccol_next  = first_col;
                    res_cchar_next = text_rd_reg[first_col*CHAR_W +: CHAR_W];
                    state_next     = ST_RESULT;
                end else if (step_row_reg == LAST_ROW) begin
                    res_done_next = 1'b1;
                    pending_next  = 1'b0;
                    state_next    = ST_RESULT;
                end else begin
                    step_row_next = row_inc;
                    rd_addr       = row_inc;
                end
            end

            // Hand the result to the output register when it is free
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Pack result fields, lowest first
    assign out_bits = {pending_reg, res_done_reg, res_cchar_reg, res_ccol_reg, res_crow_reg,
                       res_valid_reg, res_scrolled_reg, cur_row_reg, cur_col_reg};

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_FILL;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            pending_reg    <= 1'b0;
            step_row_reg   <= '0;
            fill_clear_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            pending_reg    <= pending_next;
            step_row_reg   <= step_row_next;
            fill_clear_reg <= fill_clear_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg          <= cmd_next;
        res_scrolled_reg <= res_scrolled_next;
        res_valid_reg    <= res_valid_next;
        res_crow_reg     <= res_crow_next;
        res_ccol_reg     <= res_ccol_next;
        res_cchar_reg    <= res_cchar_next;
        res_done_reg     <= res_done_next;
        if (out_load) begin
            m_tdata_reg <= OUT_W'(out_bits);
        end
    end

    // Text memory: byte-enable write, registered read
    always_ff @(posedge aclk) begin
        for (int c = 0; c < TEXT_COLS; c++) begin
            if (text_we && text_be[c]) begin
                text_mem[text_waddr][c*CHAR_W +: CHAR_W] <= text_wdata[c*CHAR_W +: CHAR_W];
            end
        end
        text_rd_reg <= text_mem[rd_addr];
    end

    // Painted-copy memory: byte-enable write, registered read
    always_ff @(posedge aclk) begin
        for (int c = 0; c < TEXT_COLS; c++) begin
            if (paint_we && paint_be[c]) begin
                paint_mem[paint_waddr][c*CHAR_W +: CHAR_W] <= paint_wdata[c*CHAR_W +: CHAR_W];
            end
        end
        paint_rd_reg <= paint_mem[rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/text_cell_layout_dirty_flush.sv */
// Text cell terminal engine: cursor layout, scroll, and changed-cell flush.
// Each item goes from the command queue through the back end's idle and result
// states to the output register; a scrolling line feed or wrap, a clear and a
// flush also sweep rows. The next command is taken after the last result is loaded.
// After reset a fill pass over all rows holds s_tready low; a 2-entry queue
// lets input continue while a result waits on m_tready.
`timescale 1ns / 1ps
`default_nettype none

module text_cell_layout_dirty_flush #(
    parameter int TEXT_ROWS = 12,
    parameter int TEXT_COLS = 16,
    localparam int COL_W    = $clog2(TEXT_COLS + 1),
    localparam int ROW_W    = $clog2(TEXT_ROWS),
    localparam int CIDX_W   = $clog2(TEXT_COLS),
    localparam int OUT_BITS = 2 * COL_W - COL_W + 2 * ROW_W + CIDX_W + 12,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] char_code
    input  wire logic [1:0]         s_tuser,   // [1:0] kind
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // cursor_col, cursor_row, scrolled, cell_valid, cell_row, cell_col,
    // cell_char, flush_done, redraw_pending, then zero fill
    output logic [OUT_W-1:0]        m_tdata
);
    import tclf_pkg::*;

    localparam int OFS_ROW  = COL_W;
    localparam int OFS_VLD  = COL_W + ROW_W + 1;
    localparam int OFS_DONE = COL_W + 2 * ROW_W + CIDX_W + 10;
    localparam int OFS_PEND = OFS_DONE + 1;

    cmd_t push_cmd, head_cmd;
    logic q_push, q_full, q_pop, head_valid, init_busy;

    tclf_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .init_busy (init_busy),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    tclf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    tclf_back #(
        .TEXT_ROWS (TEXT_ROWS),
        .TEXT_COLS (TEXT_COLS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (head_valid),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // A flush result is either a changed cell or done, never both
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[OFS_VLD] && m_tdata[OFS_DONE]))
        else $error("cell_valid and flush_done both set");

    // Reported cursor stays inside the grid or the wrap column
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OFS_ROW +: ROW_W] <= ROW_W'(TEXT_ROWS - 1))
                  && (m_tdata[COL_W-1:0] <= COL_W'(TEXT_COLS)))
        else $error("cursor out of range");

    // A completed flush leaves nothing pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[OFS_DONE]) |-> !m_tdata[OFS_PEND])
        else $error("redraw still pending after flush done");

    // No result leaves and no command is taken during the power-up fill
    assert property (@(posedge aclk) disable iff (!aresetn)
        init_busy |-> (!m_tvalid && !q_pop))
        else $error("activity during power-up fill");

endmodule

`default_nettype wire
